FILE: sv/col2im_scatter_accumulate_defines.svh
// -----------------------------------------------------------------------------
// col2im_scatter_accumulate_defines.svh
// Assertion macros shared by the fold block. Each macro expands to a clocked
// concurrent assertion on clk, disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef COL2IM_SCATTER_ACCUMULATE_DEFINES_SVH
`define COL2IM_SCATTER_ACCUMULATE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge of clk outside reset.
`define C2I_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define C2I_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define C2I_ASSERT(lbl, prop, msg)
`define C2I_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: sv/c2i_pkg.sv
// -----------------------------------------------------------------------------
// c2i_pkg
// Types and codes of the 2D fold (col2im) block: transaction payloads,
// configuration registers and accumulate results.
// -----------------------------------------------------------------------------
package c2i_pkg;

	// Operation codes
	typedef enum logic {
		OP_ACCUM = 1'b0,
		OP_READ  = 1'b1
	} op_e;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION_ROWS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION_COLS = 3'd7;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned INDEX_W = 16;

	typedef struct packed {
		logic               operation;
		logic [3:0]         channel;
		logic [2:0]         kernel_row;
		logic [2:0]         kernel_col;
		logic [5:0]         window_row;
		logic [5:0]         window_col;
		logic [5:0]         image_row;
		logic [5:0]         image_col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic               in_range;
		logic [15:0]        image_index;
		logic signed [31:0] sum_value;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic [6:0] out_height;
		logic [6:0] out_width;
		logic [5:0] pad_rows;
		logic [5:0] pad_cols;
		logic [6:0] stride_rows;
		logic [6:0] stride_cols;
		logic [3:0] dilation_rows;
		logic [3:0] dilation_cols;
	} cfg_t;

	// Outcome of one read-modify-write on a store word
	typedef struct packed {
		logic signed [31:0] store_data;
		logic signed [31:0] sum_value;
		logic               saturated;
	} acc_res_t;

endpackage

FILE: sv/c2i_ram.sv
// -----------------------------------------------------------------------------
// c2i_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// -----------------------------------------------------------------------------
module c2i_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 65536,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wen,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             ren,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/c2i_addr.sv
// -----------------------------------------------------------------------------
// c2i_addr
// Map an incoming transaction to an image position and store address, and
// check the position against the configured image and the store bounds.
// -----------------------------------------------------------------------------
module c2i_addr #(
	parameter int unsigned MAX_CHANNELS = 16,
	parameter int unsigned MAX_ROWS     = 64,
	parameter int unsigned MAX_COLS     = 64,
	parameter int unsigned MAX_KERNEL   = 8,
	parameter int unsigned MAX_WINDOWS  = 64,
	parameter int unsigned IXW          = 16
) (
	input  c2i_pkg::in_item_t  item,
	input  c2i_pkg::cfg_t      cfg,
	output logic               ok,
	output logic [IXW-1:0]     addr
);
	import c2i_pkg::*;

	logic [12:0]        row_win;
	logic [12:0]        col_win;
	logic [6:0]         row_tap;
	logic [6:0]         col_tap;
	logic signed [14:0] row_pos;
	logic signed [14:0] col_pos;
	logic               row_ok;
	logic               col_ok;
	logic               bounds_ok;

	// Small products: 6x7 for the window offset, 3x4 for the tap offset
	assign row_win = {7'd0, item.window_row} * {6'd0, cfg.stride_rows};
	assign col_win = {7'd0, item.window_col} * {6'd0, cfg.stride_cols};
	assign row_tap = {4'd0, item.kernel_row} * {3'd0, cfg.dilation_rows};
	assign col_tap = {4'd0, item.kernel_col} * {3'd0, cfg.dilation_cols};

	always_comb begin
		if (item.operation == OP_READ) begin
			row_pos   = {9'd0, item.image_row};
			col_pos   = {9'd0, item.image_col};
			bounds_ok = 32'(item.channel) < 32'(MAX_CHANNELS);
		end else begin
			row_pos   = $signed({2'd0, row_win}) + $signed({8'd0, row_tap})
			          - $signed({9'd0, cfg.pad_rows});
			col_pos   = $signed({2'd0, col_win}) + $signed({8'd0, col_tap})
			          - $signed({9'd0, cfg.pad_cols});
			bounds_ok = (32'(item.channel) < 32'(MAX_CHANNELS))
			         && (32'(item.kernel_row) < 32'(MAX_KERNEL))
			         && (32'(item.kernel_col) < 32'(MAX_KERNEL))
			         && (32'(item.window_row) < 32'(MAX_WINDOWS))
			         && (32'(item.window_col) < 32'(MAX_WINDOWS));
		end
	end

	assign row_ok = !row_pos[14] && (row_pos[13:0] < {7'd0, cfg.out_height})
	             && (32'(row_pos[13:0]) < 32'(MAX_ROWS));
	assign col_ok = !col_pos[14] && (col_pos[13:0] < {7'd0, cfg.out_width})
	             && (32'(col_pos[13:0]) < 32'(MAX_COLS));

	assign ok = bounds_ok && row_ok && col_ok;

	// Constant multiplies only; in range the address stays below the depth
	assign addr = IXW'(item.channel) * IXW'(MAX_ROWS * MAX_COLS)
	            + IXW'(row_pos[13:0]) * IXW'(MAX_COLS)
	            + IXW'(col_pos[13:0]);

endmodule

FILE: sv/c2i_acc.sv
// -----------------------------------------------------------------------------
// c2i_acc
// Modify step of the read-modify-write: pick the current word (forwarded or
// from the store), then saturating add for accumulate or clear for read.
// -----------------------------------------------------------------------------
module c2i_acc (
	input  logic                 operation,
	input  logic signed [31:0]   value,
	input  logic signed [31:0]   rdata,
	input  logic                 fwd_hit,
	input  logic signed [31:0]   fwd_data,
	output c2i_pkg::acc_res_t    res
);
	import c2i_pkg::*;

	logic signed [31:0] cur;
	logic signed [32:0] sum_wide;
	logic               ovf;
	logic signed [31:0] sum_sat;

	assign cur      = fwd_hit ? fwd_data : rdata;
	assign sum_wide = {cur[31], cur} + {value[31], value};
	assign ovf      = sum_wide[32] != sum_wide[31];
	assign sum_sat  = ovf ? (sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
	                      : sum_wide[31:0];

	always_comb begin
		if (operation == OP_READ) begin
			res.store_data = '0;
			res.sum_value  = cur;
			res.saturated  = 1'b0;
		end else begin
			res.store_data = sum_sat;
			res.sum_value  = sum_sat;
			res.saturated  = ovf;
		end
	end

endmodule

FILE: sv/col2im_scatter_accumulate.sv
// -----------------------------------------------------------------------------
// col2im_scatter_accumulate
// 2D fold (col2im): scatter column elements into an image store with
// saturating Q16.16 accumulation, and read-and-clear image elements.
// -----------------------------------------------------------------------------
// Pipeline: address + read, then modify/write-back into the output register.
// Throughput: 1 transaction per cycle unless out_stall holds the output; the
//   store's one read and one write port carry one read-modify-write per cycle,
//   with forwarding between neighbors.
// Reset: config registers take their reset values; the store is then cleared
//   one word per cycle, all MAX_CHANNELS*MAX_ROWS*MAX_COLS words (65536 at
//   the defaults), with in_stall high. Config writes are taken throughout.
// -----------------------------------------------------------------------------
`include "col2im_scatter_accumulate_defines.svh"

module col2im_scatter_accumulate #(
	parameter int unsigned MAX_CHANNELS = 16,
	parameter int unsigned MAX_ROWS     = 64,
	parameter int unsigned MAX_COLS     = 64,
	parameter int unsigned MAX_KERNEL   = 8,
	parameter int unsigned MAX_WINDOWS  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_write,
	input  logic [c2i_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c2i_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  c2i_pkg::in_item_t                   in_item,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output c2i_pkg::out_item_t                  out_item
);
	import c2i_pkg::*;

	localparam int unsigned DEPTH = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// address arithmetic width: wide enough for the store and the index port
	localparam int unsigned IXW   = (AW > INDEX_W) ? AW : INDEX_W;

	// Configuration
	cfg_t cfg_q;

	// Store clearing sweep after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Address stage (combinational on the incoming transaction)
	logic           new_ok;
	logic [IXW-1:0] new_addr;
	logic           in_xfer;

	// Modify stage
	logic               s1_valid_q;
	logic               op_s1;
	logic               ok_s1;
	logic [IXW-1:0]     addr_s1;
	logic signed [31:0] value_s1;
	logic               fwd_hit_s1;
	logic signed [31:0] fwd_data_s1;
	logic               s1_adv;
	logic               s1_wen;
	acc_res_t           acc_res;

	// Store ports
	logic          ram_wen;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	// Output register
	logic      out_valid_q;
	out_item_t out_item_q;

	// ---------------------------------------------------------------------
	// Configuration registers: plain writes, unknown indexes dropped
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_height    <= 7'd1;
			cfg_q.out_width     <= 7'd1;
			cfg_q.pad_rows      <= 6'd0;
			cfg_q.pad_cols      <= 6'd0;
			cfg_q.stride_rows   <= 7'd1;
			cfg_q.stride_cols   <= 7'd1;
			cfg_q.dilation_rows <= 4'd1;
			cfg_q.dilation_cols <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_OUT_HEIGHT:    cfg_q.out_height    <= cfg_data;
				REG_OUT_WIDTH:     cfg_q.out_width     <= cfg_data;
				REG_PAD_ROWS:      cfg_q.pad_rows      <= cfg_data[5:0];
				REG_PAD_COLS:      cfg_q.pad_cols      <= cfg_data[5:0];
				REG_STRIDE_ROWS:   cfg_q.stride_rows   <= cfg_data;
				REG_STRIDE_COLS:   cfg_q.stride_cols   <= cfg_data;
				REG_DILATION_ROWS: cfg_q.dilation_rows <= cfg_data[3:0];
				REG_DILATION_COLS: cfg_q.dilation_cols <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Clearing sweep: write zero to every word once after reset
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Address stage: position, range check and store address. The store read
	// is issued at the same edge that takes the transaction.
	// ---------------------------------------------------------------------
	c2i_addr #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_ROWS     (MAX_ROWS),
		.MAX_COLS     (MAX_COLS),
		.MAX_KERNEL   (MAX_KERNEL),
		.MAX_WINDOWS  (MAX_WINDOWS),
		.IXW          (IXW)
	) u_addr (
		.item (in_item),
		.cfg  (cfg_q),
		.ok   (new_ok),
		.addr (new_addr)
	);

	// Advance the modify stage when the output register is free or draining.
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	// Hold off new transactions during the sweep or while the stage is stuck.
	assign in_stall = clr_busy_q || (s1_valid_q && !s1_adv);
	assign in_xfer  = in_valid && !in_stall;
	// Write back only in-range transactions as they leave the stage.
	assign s1_wen   = s1_adv && ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// The read issued at this edge misses a write-back of the same word at
	// this edge; capture that write for forwarding. The stage cannot write
	// again until this transaction leaves, so the captured word stays current.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1       <= in_item.operation;
			ok_s1       <= new_ok;
			addr_s1     <= new_addr;
			value_s1    <= in_item.value;
			fwd_hit_s1  <= s1_wen && (addr_s1 == new_addr);
			fwd_data_s1 <= acc_res.store_data;
		end
	end

	// ---------------------------------------------------------------------
	// Store: sweep writes first, otherwise the stage write-back
	// ---------------------------------------------------------------------
	assign ram_wen   = clr_busy_q || s1_wen;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1[AW-1:0];
	assign ram_wdata = clr_busy_q ? 32'd0 : acc_res.store_data;

	c2i_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.wen   (ram_wen),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.ren   (in_xfer),
		.raddr (new_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Modify: saturating add or read-and-clear
	// ---------------------------------------------------------------------
	c2i_acc u_acc (
		.operation (op_s1),
		.value     (value_s1),
		.rdata     (ram_rdata),
		.fwd_hit   (fwd_hit_s1),
		.fwd_data  (fwd_data_s1),
		.res       (acc_res)
	);

	// ---------------------------------------------------------------------
	// Output register: out-of-range transactions report all zero
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_item_q.in_range    <= ok_s1;
			out_item_q.image_index <= ok_s1 ? addr_s1[INDEX_W-1:0] : '0;
			out_item_q.sum_value   <= ok_s1 ? acc_res.sum_value : '0;
			out_item_q.saturated   <= ok_s1 && acc_res.saturated;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`C2I_ASSERT_NEVER(a_no_wb_during_clear, clr_busy_q && s1_wen, "write-back during clear sweep")
	`C2I_ASSERT(a_accept_fills_stage, in_xfer |=> s1_valid_q, "accepted transaction lost")
	`C2I_ASSERT(a_fwd_only_in_stage, fwd_hit_s1 && !s1_valid_q |-> !$past(in_xfer), "stale forward")
	`C2I_ASSERT(a_clear_runs_full, $fell(clr_busy_q) |-> $past(clr_addr_q) == AW'(DEPTH - 1), "clear sweep cut short")

endmodule
